FILE: rtl/tga_pkg.sv
package tga_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    localparam logic [1:0] KIND_HEADER_OK = 2'd0;
    localparam logic [1:0] KIND_SEGMENT   = 2'd1;
    localparam logic [1:0] KIND_LAST_SEG  = 2'd2;
    localparam logic [1:0] KIND_REJECT    = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TYPE      = 3'd1;
    localparam logic [2:0] ERR_FORMAT    = 3'd2;
    localparam logic [2:0] ERR_SIZE      = 3'd3;
    localparam logic [2:0] ERR_NARROW    = 3'd4;

    localparam logic [7:0] TYPE_RAW      = 8'd2;
    localparam logic [7:0] TYPE_RLE      = 8'd10;
    localparam logic [7:0] DEPTH_24      = 8'd24;
    localparam logic [7:0] DEPTH_32      = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;
    localparam logic [4:0] HDR_LAST_IDX  = 5'd17;

    localparam logic [4:0] HDR_ID_LEN = 5'd0;
    localparam logic [4:0] HDR_CMAP   = 5'd1;
    localparam logic [4:0] HDR_TYPE   = 5'd2;
    localparam logic [4:0] HDR_W_LO   = 5'd12;
    localparam logic [4:0] HDR_W_HI   = 5'd13;
    localparam logic [4:0] HDR_H_LO   = 5'd14;
    localparam logic [4:0] HDR_H_HI   = 5'd15;
    localparam logic [4:0] HDR_DEPTH  = 5'd16;

    // command from the parser to the segment emitter
    typedef struct packed {
        logic        is_hdr;
        logic [1:0]  kind;
        logic [2:0]  err;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  count;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } cmd_t;

endpackage

FILE: rtl/tga_if.sv
interface tga_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;

    modport source (output valid, output file_byte, input ready);
    modport sink (input valid, input file_byte, output ready);
endinterface

interface tga_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  error_code;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [15:0] dest_row;
    logic [15:0] start_column;
    logic [7:0]  run_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;

    modport source (output valid, output kind, output error_code, output image_width,
                    output image_height, output dest_row, output start_column,
                    output run_length, output red, output green, output blue,
                    output alpha, output last, input ready);
    modport sink (input valid, input kind, input error_code, input image_width,
                  input image_height, input dest_row, input start_column,
                  input run_length, input red, input green, input blue,
                  input alpha, input last, output ready);
endinterface

FILE: rtl/tga_rle_image_decoder_unit.sv
// channel      dir  payload                                   handshake
// file_bytes   in   file_byte[7:0]                            valid/ready
// results      out  kind..alpha, last (segment or header)     valid/ready
// cap_wr_*     in   buffer_capacity[23:0]                     write enable only
//
// a byte is taken per cycle while the queue is not full, except in the
// size multiply and check states after the 18th header byte; the emitter
// loads a queued header or pixel word, then gives one result per row
// segment, taking no new word until done; a full 4-entry queue stops input.
// reset clears all control state; no clearing pass.
module tga_rle_image_decoder_unit #(
    parameter int DIM_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    tga_byte_if.sink     file_bytes,
    tga_result_if.source results,
    input  logic         cap_wr_en,
    input  logic [23:0]  cap_wr_data
);
    import tga_pkg::*;

    logic push, pop, full, empty;
    cmd_t push_data, pop_data;

    tga_front #(.DIM_BITS(DIM_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .file_bytes  (file_bytes),
        .cap_wr_en   (cap_wr_en),
        .cap_wr_data (cap_wr_data),
        .push        (push),
        .push_data   (push_data),
        .full        (full)
    );

    tga_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    tga_back #(.DIM_BITS(DIM_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (pop_data),
        .empty    (empty),
        .pop      (pop),
        .results  (results)
    );
endmodule

FILE: rtl/tga_cmd_fifo.sv
module tga_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tga_pkg::cmd_t push_data,
    input  logic          pop,
    output tga_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);
    import tga_pkg::*;

    cmd_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   count_reg, count_next;

    assign full     = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if ((push && !full) && !(pop && !empty))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_PTR_W-1:0])
        else $error("queue pointers disagree with count");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && full && !pop |=> count_reg == $past(count_reg))
        else $error("queue grew while full");
endmodule

FILE: rtl/tga_front.sv
module tga_front #(
    parameter int DIM_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    tga_byte_if.sink      file_bytes,
    input  logic          cap_wr_en,
    input  logic [23:0]   cap_wr_data,
    output logic          push,
    output tga_pkg::cmd_t push_data,
    input  logic          full
);
    import tga_pkg::*;

    typedef enum logic [5:0] {
        F_HDR    = 6'b000001,
        F_MUL    = 6'b000010,
        F_JUDGE  = 6'b000100,
        F_SKIP   = 6'b001000,
        F_PACKET = 6'b010000,
        F_PIXEL  = 6'b100000
    } fstate_t;

    localparam logic [16:0] DIM_MAX = (17'd1 << DIM_BITS) - 17'd1;

    fstate_t      st_reg, st_next;
    logic [4:0]   hidx_reg, hidx_next;
    logic [23:0]  cap_reg;
    logic [7:0]   id_len_reg, cmap_reg, type_reg, depth_reg;
    logic [15:0]  w_reg, h_reg;
    logic [31:0]  prod_reg;
    logic [31:0]  left_reg, left_next;
    logic [7:0]   skip_reg, skip_next;
    logic [1:0]   pidx_reg, pidx_next;
    logic [7:0]   c0_reg, c1_reg, c2_reg;
    logic [7:0]   pkt_reg, pkt_next;
    logic         run_reg, run_next;

    logic         acc;
    logic         pb4;
    logic [33:0]  size;
    logic [2:0]   err;
    logic         empty_img;
    fstate_t      pix_start;
    logic [7:0]   b;
    logic         pix_done;
    logic [7:0]   cnt;

    assign b    = file_bytes.file_byte;
    assign acc  = file_bytes.valid && file_bytes.ready;
    assign pb4  = (depth_reg == DEPTH_32);
    assign size = pb4 ? {prod_reg, 2'b00} : ({2'b00, prod_reg} + {1'b0, prod_reg, 1'b0});
    assign empty_img = (w_reg == '0) || (h_reg == '0);
    assign pix_start = empty_img ? F_HDR : ((type_reg == TYPE_RLE) ? F_PACKET : F_PIXEL);
    assign pix_done  = pb4 ? (pidx_reg == 2'd3) : (pidx_reg == 2'd2);
    assign cnt       = (type_reg == TYPE_RLE && run_reg) ? pkt_reg : 8'd1;

    always_comb
    begin
        file_bytes.ready = !full && (st_reg == F_HDR || st_reg == F_SKIP ||
                                     st_reg == F_PACKET || st_reg == F_PIXEL);
    end

    always_comb
    begin
        if (type_reg != TYPE_RAW && type_reg != TYPE_RLE)
        begin
            err = ERR_TYPE;
        end
        else if (cmap_reg != '0 || (depth_reg != DEPTH_32 && depth_reg != DEPTH_24))
        begin
            err = ERR_FORMAT;
        end
        else if ({1'b0, w_reg} > DIM_MAX || {1'b0, h_reg} > DIM_MAX ||
                 size > {10'd0, cap_reg})
        begin
            err = ERR_SIZE;
        end
        else if (w_reg != '0 && w_reg < 16'd4)
        begin
            err = ERR_NARROW;
        end
        else
        begin
            err = ERR_NONE;
        end
    end

    always_comb
    begin
        st_next   = st_reg;
        hidx_next = hidx_reg;
        left_next = left_reg;
        skip_next = skip_reg;
        pidx_next = pidx_reg;
        pkt_next  = pkt_reg;
        run_next  = run_reg;
        push      = 1'b0;
        push_data = '0;
        unique case (st_reg)
            F_HDR:
            begin
                if (acc)
                begin
                    if (hidx_reg == HDR_LAST_IDX)
                    begin
                        hidx_next = '0;
                        st_next   = F_MUL;
                    end
                    else
                    begin
                        hidx_next = hidx_reg + 1'b1;
                    end
                end
            end
            F_MUL:
            begin
                st_next = F_JUDGE;
            end
            F_JUDGE:
            begin
                if (!full)
                begin
                    push             = 1'b1;
                    push_data.is_hdr = 1'b1;
                    push_data.err    = err;
                    if (err != ERR_NONE)
                    begin
                        push_data.kind = KIND_REJECT;
                        st_next        = F_HDR;
                    end
                    else
                    begin
                        push_data.kind = KIND_HEADER_OK;
                        left_next      = prod_reg;
                        pidx_next      = '0;
                        pkt_next       = '0;
                        run_next       = 1'b0;
                        if (id_len_reg != '0)
                        begin
                            skip_next = id_len_reg;
                            st_next   = F_SKIP;
                        end
                        else
                        begin
                            st_next = pix_start;
                        end
                    end
                    if (err == ERR_SIZE || err == ERR_NARROW || err == ERR_NONE)
                    begin
                        push_data.width  = w_reg;
                        push_data.height = h_reg;
                    end
                end
            end
            F_SKIP:
            begin
                if (acc)
                begin
                    skip_next = skip_reg - 1'b1;
                    if (skip_reg <= 8'd1)
                    begin
                        st_next = pix_start;
                    end
                end
            end
            F_PACKET:
            begin
                if (acc)
                begin
                    pkt_next  = {1'b0, b[6:0]} + 8'd1;
                    run_next  = b[7];
                    pidx_next = '0;
                    st_next   = F_PIXEL;
                end
            end
            F_PIXEL:
            begin
                if (acc)
                begin
                    pidx_next = pidx_reg + 1'b1;
                    if (pix_done)
                    begin
                        pidx_next       = '0;
                        push            = 1'b1;
                        push_data.count = cnt;
                        push_data.blue  = c0_reg;
                        push_data.green = c1_reg;
                        push_data.red   = pb4 ? c2_reg : b;
                        push_data.alpha = pb4 ? b : ALPHA_OPAQUE;
                        if (type_reg == TYPE_RLE)
                        begin
                            if (run_reg)
                            begin
                                pkt_next = '0;
                                st_next  = F_PACKET;
                            end
                            else
                            begin
                                pkt_next = pkt_reg - 1'b1;
                                if (pkt_reg <= 8'd1)
                                begin
                                    st_next = F_PACKET;
                                end
                            end
                        end
                        // image ends with this word: back to header parsing
                        if ({24'd0, cnt} >= left_reg)
                        begin
                            left_next = '0;
                            st_next   = F_HDR;
                        end
                        else
                        begin
                            left_next = left_reg - {24'd0, cnt};
                        end
                    end
                end
            end
            default:
            begin
                st_next = F_HDR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= F_HDR;
            hidx_reg <= '0;
            cap_reg  <= 24'd20480;
            left_reg <= '0;
            skip_reg <= '0;
            pidx_reg <= '0;
            pkt_reg  <= '0;
            run_reg  <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            hidx_reg <= hidx_next;
            left_reg <= left_next;
            skip_reg <= skip_next;
            pidx_reg <= pidx_next;
            pkt_reg  <= pkt_next;
            run_reg  <= run_next;
            if (cap_wr_en)
            begin
                cap_reg <= cap_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == F_MUL)
        begin
            prod_reg <= w_reg * h_reg;
        end
        if (acc && st_reg == F_HDR)
        begin
            case (hidx_reg)
                HDR_ID_LEN: id_len_reg  <= b;
                HDR_CMAP:   cmap_reg    <= b;
                HDR_TYPE:   type_reg    <= b;
                HDR_W_LO:   w_reg[7:0]  <= b;
                HDR_W_HI:   w_reg[15:8] <= b;
                HDR_H_LO:   h_reg[7:0]  <= b;
                HDR_H_HI:   h_reg[15:8] <= b;
                HDR_DEPTH:  depth_reg   <= b;
                default:    ;
            endcase
        end
        if (acc && st_reg == F_PIXEL)
        begin
            case (pidx_reg)
                2'd0:    c0_reg <= b;
                2'd1:    c1_reg <= b;
                2'd2:    c2_reg <= b;
                default: ;
            endcase
        end
    end
endmodule

FILE: rtl/tga_back.sv
module tga_back #(
    parameter int DIM_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tga_pkg::cmd_t pop_data,
    input  logic          empty,
    output logic          pop,
    tga_result_if.source  results
);
    import tga_pkg::*;

    cmd_t                cmd_reg;
    logic                busy_reg;
    logic [7:0]          cnt_reg;
    logic [DIM_BITS-1:0] w_reg, row_reg, col_reg;
    logic [15:0]         img_w_reg, img_h_reg;
    logic                ov_reg;

    logic                step;
    logic [DIM_BITS-1:0] room;
    logic                row_end;
    logic                done;
    logic [7:0]          n;

    assign pop     = !busy_reg && !empty;
    assign step    = busy_reg && (!ov_reg || results.ready);
    assign room    = w_reg - col_reg;
    assign row_end = (DIM_BITS'(cnt_reg) >= room);
    assign done    = row_end && (row_reg == '0);
    assign n       = row_end ? room[7:0] : cnt_reg;
    assign results.valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (step && (cmd_reg.is_hdr || done || !(DIM_BITS'(cnt_reg) > room)))
            begin
                busy_reg <= 1'b0;
            end
            if (step)
            begin
                ov_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= pop_data;
            cnt_reg <= pop_data.count;
        end
        if (step)
        begin
            results.image_width  <= cmd_reg.is_hdr ? cmd_reg.width : img_w_reg;
            results.image_height <= cmd_reg.is_hdr ? cmd_reg.height : img_h_reg;
            if (cmd_reg.is_hdr)
            begin
                results.kind         <= cmd_reg.kind;
                results.error_code   <= cmd_reg.err;
                results.dest_row     <= '0;
                results.start_column <= '0;
                results.run_length   <= '0;
                results.red          <= '0;
                results.green        <= '0;
                results.blue         <= '0;
                results.alpha        <= '0;
                results.last         <= 1'b1;
                if (cmd_reg.kind == KIND_HEADER_OK)
                begin
                    img_w_reg <= cmd_reg.width;
                    img_h_reg <= cmd_reg.height;
                    w_reg     <= cmd_reg.width[DIM_BITS-1:0];
                    row_reg   <= cmd_reg.height[DIM_BITS-1:0] - 1'b1;
                    col_reg   <= '0;
                end
            end
            else
            begin
                results.kind         <= done ? KIND_LAST_SEG : KIND_SEGMENT;
                results.error_code   <= ERR_NONE;
                results.dest_row     <= 16'(row_reg);
                results.start_column <= 16'(col_reg);
                results.run_length   <= n;
                results.red          <= cmd_reg.red;
                results.green        <= cmd_reg.green;
                results.blue         <= cmd_reg.blue;
                results.alpha        <= cmd_reg.alpha;
                results.last         <= done || !(DIM_BITS'(cnt_reg) > room);
                cnt_reg              <= cnt_reg - n;
                if (row_end)
                begin
                    col_reg <= '0;
                    if (row_reg != '0)
                    begin
                        row_reg <= row_reg - 1'b1;
                    end
                end
                else
                begin
                    col_reg <= col_reg + DIM_BITS'(n);
                end
            end
        end
    end

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !pop)
        else $error("command taken while one is in progress");
    a_seg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        step && !cmd_reg.is_hdr |-> n != 8'd0)
        else $error("empty pixel segment");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !results.ready |=> ov_reg && $stable(results.run_length))
        else $error("stalled result changed");
endmodule

FILE: tb/tga_rle_image_decoder_unit_tb.sv
module tga_rle_image_decoder_unit_tb;
    import tga_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int PH_HDR  = 0;
    localparam int PH_SKIP = 1;
    localparam int PH_PKT  = 2;
    localparam int PH_PIX  = 3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  err;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] row;
        logic [15:0] col;
        logic [7:0]  len;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
    } segment_t;

    logic        clk;
    logic        rst_n;
    logic        cap_wr_en;
    logic [23:0] cap_wr_data;

    tga_byte_if   bi();
    tga_result_if ri();

    tga_rle_image_decoder_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .file_bytes  (bi),
        .results     (ri),
        .cap_wr_en   (cap_wr_en),
        .cap_wr_data (cap_wr_data)
    );

    // decoder shadow state
    logic [7:0] hdr[18];
    logic [7:0] color[4];
    int         hdr_idx;
    int         dec_phase;
    int         skip_left;
    int         pix_idx;
    int         pkt_left;
    bit         pkt_run;
    int         cur_row;
    int         cur_col;
    longint     capacity;

    segment_t   pending_q[$];
    int         mismatches;
    int         stall_cycles;
    int         stall_left;
    int         bytes_sent;
    bit         no_idle;

    always #4 clk = ~clk;

    function automatic int hdr_width();
        return int'({hdr[HDR_W_HI], hdr[HDR_W_LO]});
    endfunction

    function automatic int hdr_height();
        return int'({hdr[HDR_H_HI], hdr[HDR_H_LO]});
    endfunction

    function automatic int bytes_per_pixel();
        return (hdr[HDR_DEPTH] == DEPTH_32) ? 4 : 3;
    endfunction

    task automatic push_segment(input logic [1:0] kind, input logic [2:0] err, input int w,
                                input int h, input int row, input int col, input int len,
                                input bit colored);
        segment_t s;
        s.kind   = kind;
        s.err    = err;
        s.width  = w[15:0];
        s.height = h[15:0];
        s.row    = row[15:0];
        s.col    = col[15:0];
        s.len    = len[7:0];
        s.red    = colored ? color[2] : 8'd0;
        s.green  = colored ? color[1] : 8'd0;
        s.blue   = colored ? color[0] : 8'd0;
        s.alpha  = colored ? color[3] : 8'd0;
        s.last   = 1'b0;
        pending_q.push_back(s);
    endtask

    task automatic begin_pixels();
        if (hdr_width() == 0 || hdr_height() == 0)
        begin
            dec_phase = PH_HDR;
            return;
        end
        cur_row   = hdr_height() - 1;
        cur_col   = 0;
        pix_idx   = 0;
        pkt_left  = 0;
        pkt_run   = 0;
        dec_phase = (hdr[HDR_TYPE] == TYPE_RLE) ? PH_PKT : PH_PIX;
    endtask

    // split a run of the held color at row ends
    task automatic emit_run(input int count);
        int w;
        int h;
        int room;
        int n;
        int row;
        int col;
        bit done;
        w = hdr_width();
        h = hdr_height();
        while (count > 0)
        begin
            room = w - cur_col;
            n    = (count < room) ? count : room;
            row  = cur_row;
            col  = cur_col;
            done = 0;
            cur_col += n;
            count   -= n;
            if (cur_col >= w)
            begin
                cur_col = 0;
                if (cur_row == 0)
                    done = 1;
                else
                    cur_row--;
            end
            push_segment(done ? KIND_LAST_SEG : KIND_SEGMENT, ERR_NONE, w, h, row, col, n, 1);
            if (done)
            begin
                dec_phase = PH_HDR;
                pkt_left  = 0;
                break;
            end
        end
    endtask

    task automatic judge_header();
        logic [2:0] err;
        int w;
        int h;
        w   = hdr_width();
        h   = hdr_height();
        err = ERR_NONE;
        if (hdr[HDR_TYPE] != TYPE_RAW && hdr[HDR_TYPE] != TYPE_RLE)
            err = ERR_TYPE;
        else if (hdr[HDR_CMAP] != 0 || (hdr[HDR_DEPTH] != DEPTH_32 && hdr[HDR_DEPTH] != DEPTH_24))
            err = ERR_FORMAT;
        else if (longint'(w) * longint'(h) * longint'(bytes_per_pixel()) > capacity)
            err = ERR_SIZE;
        else if (w >= 1 && w <= 3)
            err = ERR_NARROW;
        if (err != ERR_NONE)
        begin
            if (err >= ERR_SIZE)
                push_segment(KIND_REJECT, err, w, h, 0, 0, 0, 0);
            else
                push_segment(KIND_REJECT, err, 0, 0, 0, 0, 0, 0);
            dec_phase = PH_HDR;
            return;
        end
        push_segment(KIND_HEADER_OK, ERR_NONE, w, h, 0, 0, 0, 0);
        if (hdr[HDR_ID_LEN] != 0)
        begin
            skip_left = int'(hdr[HDR_ID_LEN]);
            dec_phase = PH_SKIP;
        end
        else
            begin_pixels();
    endtask

    task automatic decode_byte(input logic [7:0] b);
        int       before_cnt;
        int       cnt;
        segment_t s;
        before_cnt = pending_q.size();
        case (dec_phase)
            PH_HDR:
            begin
                hdr[hdr_idx] = b;
                hdr_idx++;
                if (hdr_idx == 18)
                begin
                    hdr_idx = 0;
                    judge_header();
                end
            end
            PH_SKIP:
            begin
                if (skip_left > 0)
                    skip_left--;
                if (skip_left == 0)
                    begin_pixels();
            end
            PH_PKT:
            begin
                pkt_left  = int'(b[6:0]) + 1;
                pkt_run   = b[7];
                pix_idx   = 0;
                dec_phase = PH_PIX;
            end
            default:
            begin
                color[pix_idx] = b;
                pix_idx++;
                if (pix_idx == bytes_per_pixel())
                begin
                    pix_idx = 0;
                    if (bytes_per_pixel() == 3)
                        color[3] = ALPHA_OPAQUE;
                    if (hdr[HDR_TYPE] != TYPE_RLE)
                        emit_run(1);
                    else if (pkt_run)
                    begin
                        cnt       = pkt_left;
                        pkt_left  = 0;
                        dec_phase = PH_PKT;
                        emit_run(cnt);
                    end
                    else
                    begin
                        pkt_left--;
                        if (pkt_left == 0)
                            dec_phase = PH_PKT;
                        emit_run(1);
                    end
                end
            end
        endcase
        if (pending_q.size() > before_cnt)
        begin
            s = pending_q.pop_back();
            s.last = 1'b1;
            pending_q.push_back(s);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (!no_idle && $urandom_range(0, 4) == 0)
        begin
            bi.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        bi.valid     <= 1'b1;
        bi.file_byte <= b;
        do
            @(posedge clk);
        while (!bi.ready);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic send_header(input int id_len, input int cmap, input int typ, input int w,
                               input int h, input int depth);
        send_byte(id_len[7:0]);
        send_byte(cmap[7:0]);
        send_byte(typ[7:0]);
        repeat (9) send_byte(8'($urandom_range(0, 255)));
        send_byte(w[7:0]);
        send_byte(w[15:8]);
        send_byte(h[7:0]);
        send_byte(h[15:8]);
        send_byte(depth[7:0]);
        send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_pixel(input int depth);
        repeat ((depth == DEPTH_32) ? 4 : 3) send_byte(8'($urandom_range(0, 255)));
    endtask

    // id field, then well-formed pixel data (random packets for RLE)
    task automatic send_body(input int id_len, input int typ, input int w, input int h,
                             input int depth);
        int         left;
        int         n;
        logic [7:0] pk;
        repeat (id_len) send_byte(8'($urandom_range(0, 255)));
        left = w * h;
        while (left > 0)
        begin
            if (typ == TYPE_RLE)
            begin
                pk = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 2) != 0)
                    pk[6:3] = 4'd0;
                n = int'(pk[6:0]) + 1;
                send_byte(pk);
                if (pk[7])
                begin
                    send_pixel(depth);
                    left -= n;
                end
                else
                    while (n > 0 && left > 0)
                    begin
                        send_pixel(depth);
                        n--;
                        left--;
                    end
            end
            else
            begin
                send_pixel(depth);
                left--;
            end
        end
    endtask

    task automatic wait_drained();
        bi.valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [23:0] v);
        wait_drained();
        cap_wr_en   <= 1'b1;
        cap_wr_data <= v;
        @(posedge clk);
        cap_wr_en <= 1'b0;
        capacity = longint'(v);
    endtask

    task automatic test_rejects();
        send_header(0, 0, 1, 4, 4, DEPTH_24);
        send_header(0, 0, TYPE_RLE, 4, 4, 16);
        send_header(0, 0, TYPE_RLE, 2, 2, DEPTH_24);
    endtask

    task automatic test_raw_and_empty();
        send_header(2, 0, TYPE_RAW, 0, 5, DEPTH_24);
        send_body(2, TYPE_RAW, 0, 5, DEPTH_24);
    endtask

    task automatic test_rle_spans();
        // one pixel, then two full runs crossing many rows from mid-row; the second runs past the image end
        send_header(0, 0, TYPE_RLE, 4, 40, DEPTH_32);
        send_byte(8'h00);
        send_pixel(DEPTH_32);
        send_byte(8'hff);
        send_pixel(DEPTH_32);
        send_byte(8'hff);
        send_pixel(DEPTH_32);
        // raw packet longer than the image; only the image's pixels are sent
        send_header(0, 0, TYPE_RLE, 4, 1, DEPTH_24);
        send_byte(8'h07);
        repeat (4) send_pixel(DEPTH_24);
    endtask

    task automatic test_capacity();
        set_capacity(24'd0);
        send_header(0, 0, TYPE_RLE, 0, 0, DEPTH_32);
        set_capacity(24'd24);
        send_header(0, 0, TYPE_RAW, 4, 2, DEPTH_24);
        send_body(0, TYPE_RAW, 4, 2, DEPTH_24);
        // rejected image: its id field is not skipped
        send_header(3, 0, TYPE_RAW, 4, 2, DEPTH_32);
    endtask

    task automatic random_images(input int goal);
        int w;
        int h;
        int id_len;
        int typ;
        int depth;
        int stop_at;
        stop_at = bytes_sent + goal;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 7) == 0)
                repeat (18) send_byte(8'($urandom_range(0, 255)));
            else
            begin
                w      = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 8);
                h      = $urandom_range(0, 5);
                id_len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
                typ    = $urandom_range(0, 1) ? int'(TYPE_RLE) : int'(TYPE_RAW);
                depth  = $urandom_range(0, 1) ? int'(DEPTH_32) : int'(DEPTH_24);
                if ($urandom_range(0, 9) == 0)
                    w = $urandom_range(0, 65535);
                send_header(id_len, 0, typ, w, h, depth);
                if (w == 0 || h == 0 || (w >= 4 && w * h * bytes_per_pixel() <= capacity))
                    send_body(id_len, typ, w, h, depth);
            end
        end
    endtask

    task automatic test_random();
        set_capacity(24'd20480);
        random_images(30);
        set_capacity(24'($urandom_range(60, 200)));
        no_idle = 1;
        random_images(30);
    endtask

    // result side: random back-pressure (none once no_idle is set) and checking
    always @(posedge clk)
    begin
        segment_t got;
        segment_t want;
        if (ri.valid && ri.ready)
        begin
            got.kind   = ri.kind;
            got.err    = ri.error_code;
            got.width  = ri.image_width;
            got.height = ri.image_height;
            got.row    = ri.dest_row;
            got.col    = ri.start_column;
            got.len    = ri.run_length;
            got.red    = ri.red;
            got.green  = ri.green;
            got.blue   = ri.blue;
            got.alpha  = ri.alpha;
            got.last   = ri.last;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %h", got);
            end
            else
            begin
                want = pending_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
        if (no_idle)
            ri.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            ri.ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 7) - 1;
            ri.ready <= 1'b0;
        end
        else
            ri.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((bi.valid && bi.ready) || (ri.valid && ri.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        cap_wr_en    = 1'b0;
        cap_wr_data  = 24'd0;
        bi.valid     = 1'b0;
        bi.file_byte = 8'd0;
        ri.ready     = 1'b0;
        mismatches   = 0;
        stall_cycles = 0;
        stall_left   = 0;
        bytes_sent   = 0;
        no_idle      = 0;
        capacity     = 20480;
        hdr_idx      = 0;
        dec_phase    = PH_HDR;
        skip_left    = 0;
        pix_idx      = 0;
        pkt_left     = 0;
        pkt_run      = 0;
        cur_row      = 0;
        cur_col      = 0;
        foreach (hdr[i]) hdr[i] = 8'd0;
        foreach (color[i]) color[i] = 8'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_rejects();
        test_raw_and_empty();
        test_rle_spans();
        test_capacity();
        test_random();

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/tga_pkg.sv
rtl/tga_if.sv
rtl/tga_cmd_fifo.sv
rtl/tga_front.sv
rtl/tga_back.sv
rtl/tga_rle_image_decoder_unit.sv
tb/tga_rle_image_decoder_unit_tb.sv
